// ----- src/hde_pkg.sv -----
// Shared types, constants and table builders for the Huber density evaluator.
`timescale 1ns / 1ps
`default_nettype none
package hde_pkg;

	// Q8.16 distance and exponent limit
	localparam logic [23:0] Z_MAX = 24'hFFFFFF;
	// exp(-1) in Q0.32
	localparam logic [63:0] EXP_NEG1_Q32 = 64'd1580030169;
	// table entries are Q0.30, with 1.0 itself representable
	localparam int unsigned QW = 31;

	typedef logic [QW-1:0] q30_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CENTER         = 2'd0,
		REG_INV_SCALE      = 2'd1,
		REG_TAIL_THRESHOLD = 2'd2,
		REG_NORM_COEFF     = 2'd3
	} cfg_reg_t;

	// per-word flags that travel down the pipeline
	typedef struct packed {
		logic valid;
		logic tail;
		logic zero;
	} flags_t;

	// divide by a small series index (elaboration only)
	function automatic logic [63:0] div_small(input logic [63:0] x, input logic [4:0] n);
		logic [63:0] r;
		case (n)
			5'd1:    r = x;
			5'd2:    r = x / 64'd2;
			5'd3:    r = x / 64'd3;
			5'd4:    r = x / 64'd4;
			5'd5:    r = x / 64'd5;
			5'd6:    r = x / 64'd6;
			5'd7:    r = x / 64'd7;
			5'd8:    r = x / 64'd8;
			5'd9:    r = x / 64'd9;
			5'd10:   r = x / 64'd10;
			5'd11:   r = x / 64'd11;
			5'd12:   r = x / 64'd12;
			5'd13:   r = x / 64'd13;
			5'd14:   r = x / 64'd14;
			5'd15:   r = x / 64'd15;
			5'd16:   r = x / 64'd16;
			default: r = x;
		endcase
		return r;
	endfunction

	// exp(-idx) in Q0.30, by repeated rounded multiplication by exp(-1)
	function automatic q30_t rom_int_entry(input int unsigned idx);
		logic [63:0] p;
		p = 64'd1 << 32;
		for (int unsigned k = 0; k < idx; k++) begin
			p = (p * EXP_NEG1_Q32 + (64'd1 << 31)) >> 32;
		end
		return QW'((p + 64'd2) >> 2);
	endfunction

	// exp(-idx / 2^bits) in Q0.30, by a 16-term Taylor series in Q0.32
	function automatic q30_t rom_frac_entry(input int unsigned idx, input int unsigned bits);
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] sum;
		t    = 64'(idx) << (32 - bits);
		term = 64'd1 << 32;
		sum  = 64'd1 << 32;
		for (int unsigned n = 1; n <= 16; n++) begin
			term = div_small((term * t) >> 32, 5'(n));
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return QW'((sum + 64'd2) >> 2);
	endfunction

endpackage
`default_nettype wire

// ----- src/hde_dist.sv -----
// Stages 1-3: distance from center, scaling, and core/tail operand select.
`timescale 1ns / 1ps
`default_nettype none
module hde_dist (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_valid,
	input  wire logic signed [31:0]  sample_value,
	input  wire logic signed [31:0]  center,
	input  wire logic        [31:0]  inv_scale,
	input  wire logic        [23:0]  tail_threshold,
	output hde_pkg::flags_t          flags,
	output logic             [23:0]  op_a,
	output logic             [24:0]  op_b
);

	logic              valid_s1, valid_s2;
	logic [31:0]       mag_s1;
	logic [63:0]       prod_s2;
	logic [23:0]       op_a_s3;
	logic [24:0]       op_b_s3;
	hde_pkg::flags_t   flags_s3;

	logic signed [32:0] diff;
	logic        [31:0] mag_full;
	logic        [63:0] z_round;
	logic        [47:0] z_wide;
	logic        [23:0] z;
	logic               ovf;
	logic               tail;

	// stage 1: |x - center|, fits 32 bits
	always_comb begin
		diff     = {sample_value[31], sample_value} - {center[31], center};
		mag_full = diff[32] ? 32'(-diff) : 32'(diff);
	end

	// stage 3: rounded Q8.16 distance and multiplier operands
	// core: z*z; tail: v*(2z - v) == 2vz - v*v
	always_comb begin
		z_round = prod_s2 + 64'h8000;
		z_wide  = z_round[63:16];
		ovf     = |z_wide[47:24];
		z       = z_wide[23:0];
		tail    = ovf || (z > tail_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_s3 <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			flags_s3 <= '{valid: valid_s2, tail: tail, zero: ovf};
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag_full;
			prod_s2 <= 64'(mag_s1) * 64'(inv_scale);
			if (tail) begin
				op_a_s3 <= tail_threshold;
				op_b_s3 <= {z, 1'b0} - {1'b0, tail_threshold};
			end else begin
				op_a_s3 <= z;
				op_b_s3 <= {1'b0, z};
			end
		end
	end

	assign flags = flags_s3;
	assign op_a  = op_a_s3;
	assign op_b  = op_b_s3;

endmodule
`default_nettype wire

// ----- src/hde_expo.sv -----
// Stages 4-7: exponent, exp table lookup and table product.
`timescale 1ns / 1ps
`default_nettype none
module hde_expo #(
	parameter int unsigned EXP_LUT_BITS = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire hde_pkg::flags_t in_flags,
	input  wire logic [23:0]     op_a,
	input  wire logic [24:0]     op_b,
	output hde_pkg::flags_t      out_flags,
	output hde_pkg::q30_t        g
);

	localparam int unsigned LUT_SIZE = 1 << EXP_LUT_BITS;

	hde_pkg::q30_t rom_int  [LUT_SIZE];
	hde_pkg::q30_t rom_frac [LUT_SIZE];

	// constant tables, built at elaboration
	for (genvar gi = 0; gi < LUT_SIZE; gi++) begin : g_rom
		localparam hde_pkg::q30_t EI = hde_pkg::rom_int_entry(gi);
		localparam hde_pkg::q30_t EF = hde_pkg::rom_frac_entry(gi, EXP_LUT_BITS);
		assign rom_int[gi]  = EI;
		assign rom_frac[gi] = EF;
	end

	hde_pkg::flags_t   flags_s4, flags_s5, flags_s6, flags_s7;
	logic [48:0]       tm_s4;
	hde_pkg::q30_t     ei_s5, ef_s5;
	logic [61:0]       gp_s6;
	hde_pkg::q30_t     g_s7;

	logic [49:0]               m_round;
	logic [32:0]               m_wide;
	logic [23:0]               m;
	logic [7:0]                ipart;
	logic                      beyond;
	logic [EXP_LUT_BITS-1:0]   int_idx;
	logic [EXP_LUT_BITS-1:0]   frac_idx;
	logic [61:0]               g_round;

	// stage 5: Q8.16 exponent from 2m, saturated, split into table indexes
	always_comb begin
		m_round  = 50'(tm_s4) + 50'h10000;
		m_wide   = m_round[49:17];
		m        = (|m_wide[32:24]) ? hde_pkg::Z_MAX : m_wide[23:0];
		ipart    = m[23:16];
		beyond   = 32'(ipart) >= LUT_SIZE;
		int_idx  = EXP_LUT_BITS'(ipart);
		frac_idx = m[15:16-EXP_LUT_BITS];
	end

	// stage 7: round product back to Q0.30
	assign g_round = gp_s6 + (62'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s4 <= '0;
			flags_s5 <= '0;
			flags_s6 <= '0;
			flags_s7 <= '0;
		end else if (adv) begin
			flags_s4 <= in_flags;
			flags_s5 <= '{valid: flags_s4.valid, tail: flags_s4.tail,
				zero: flags_s4.zero || beyond};
			flags_s6 <= flags_s5;
			flags_s7 <= flags_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tm_s4 <= 49'(op_a) * 49'(op_b);
			ei_s5 <= rom_int[int_idx];
			ef_s5 <= rom_frac[frac_idx];
			gp_s6 <= 62'(ei_s5) * 62'(ef_s5);
			g_s7  <= flags_s6.zero ? '0 : g_round[60:30];
		end
	end

	assign out_flags = flags_s7;
	assign g         = g_s7;

endmodule
`default_nettype wire

// ----- src/hde_scale.sv -----
// Stage 8 and output register: normalization, rounding and stall control.
`timescale 1ns / 1ps
`default_nettype none
module hde_scale (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hde_pkg::flags_t in_flags,
	input  wire hde_pkg::q30_t   g,
	input  wire logic [31:0]     norm_coeff,
	input  wire logic            out_ready,
	output logic                 adv,
	output logic                 out_valid,
	output logic [31:0]          density,
	output logic                 in_tail
);

	logic              valid_s8, tail_s8;
	logic [62:0]       dp_s8;
	logic              out_valid_q;
	logic [31:0]       density_q;
	logic              tail_q;

	logic [63:0]       d_round;
	logic [33:0]       d_wide;
	logic [31:0]       d_sat;

	// whole pipeline moves when the output word is free or being taken
	assign adv = !out_valid_q || out_ready;

	// round Q16.16 result and saturate
	always_comb begin
		d_round = 64'(dp_s8) + (64'd1 << 29);
		d_wide  = d_round[63:30];
		d_sat   = (|d_wide[33:32]) ? 32'hFFFF_FFFF : d_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s8    <= in_flags.valid;
			out_valid_q <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s8     <= 63'(g) * 63'(norm_coeff);
			tail_s8   <= in_flags.tail;
			density_q <= d_sat;
			tail_q    <= tail_s8;
		end
	end

	assign out_valid = out_valid_q;
	assign density   = density_q;
	assign in_tail   = tail_q;

endmodule
`default_nettype wire

// ----- src/huber_density_evaluator_top.sv -----
// Top level of the Huber density evaluator: config registers, pipeline and stream ports.
`timescale 1ns / 1ps
`default_nettype none
// Evaluates the Huber density at each Q16.16 sample word: z = |x - center| * inv_scale
// (Q8.16), exponent z*z/2 in the core or v*z - v*v/2 in the tail, exp() from two
// 2^EXP_LUT_BITS-entry constant tables, then scaling by norm_coeff. A new sample is
// taken every cycle unless downstream backpressure stalls the pipeline; a result passes
// through the eight pipeline stages around the four multipliers (distance scale,
// exponent, table product, normalization) plus the output register, the first stage
// capturing the word at the accepting edge. Configuration registers take effect at
// once; the user must write them only while the pipeline is empty, which the block
// does not enforce. Downstream backpressure stalls the whole pipeline without loss.
module huber_density_evaluator_top #(
	parameter int unsigned EXP_LUT_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,    // [31:0] sample_value
	// density stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,    // [31:0] density
	output logic             m_tuser,    // [0] in_tail
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	logic signed [31:0] center_q;
	logic        [31:0] inv_scale_q;
	logic        [23:0] tail_threshold_q;
	logic        [31:0] norm_coeff_q;

	logic               adv;
	hde_pkg::flags_t    dist_flags;
	logic        [23:0] op_a;
	logic        [24:0] op_b;
	hde_pkg::flags_t    exp_flags;
	hde_pkg::q30_t      exp_g;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q         <= 32'sd0;
			inv_scale_q      <= 32'd65536;
			tail_threshold_q <= 24'd98304;
			norm_coeff_q     <= 32'd26145;
		end else if (cfg_we) begin
			case (hde_pkg::cfg_reg_t'(cfg_addr))
				hde_pkg::REG_CENTER:         center_q         <= cfg_wdata;
				hde_pkg::REG_INV_SCALE:      inv_scale_q      <= cfg_wdata;
				hde_pkg::REG_TAIL_THRESHOLD: tail_threshold_q <= cfg_wdata[23:0];
				hde_pkg::REG_NORM_COEFF:     norm_coeff_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = adv;

	hde_dist u_dist (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.in_valid       (s_tvalid),
		.sample_value   (s_tdata),
		.center         (center_q),
		.inv_scale      (inv_scale_q),
		.tail_threshold (tail_threshold_q),
		.flags          (dist_flags),
		.op_a           (op_a),
		.op_b           (op_b)
	);

	hde_expo #(
		.EXP_LUT_BITS (EXP_LUT_BITS)
	) u_expo (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_flags  (dist_flags),
		.op_a      (op_a),
		.op_b      (op_b),
		.out_flags (exp_flags),
		.g         (exp_g)
	);

	hde_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_flags   (exp_flags),
		.g          (exp_g),
		.norm_coeff (norm_coeff_q),
		.out_ready  (m_tready),
		.adv        (adv),
		.out_valid  (m_tvalid),
		.density    (m_tdata),
		.in_tail    (m_tuser)
	);

	// distance overflow is always reported as tail
	a_ovf_is_tail: assert property (@(posedge clk) disable iff (!arst_n)
		dist_flags.valid && dist_flags.zero |-> dist_flags.tail)
		else $error("distance overflow word not marked as tail");

	// a zeroed word carries a zero table product
	a_zero_g: assert property (@(posedge clk) disable iff (!arst_n)
		exp_flags.valid && exp_flags.zero |-> exp_g == '0)
		else $error("zeroed word has nonzero exp product");

	// a stall freezes the inner stages
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && exp_flags.valid |=> exp_flags.valid && $stable(exp_g))
		else $error("pipeline stage changed during stall");

endmodule
`default_nettype wire

// ----- test/huber_density_evaluator_top_tb.sv -----
// Self-checking testbench for the Huber density evaluator stream pipeline.
`timescale 1ns / 1ps
module huber_density_evaluator_top_tb;

	localparam int unsigned LUT_BITS       = 8;
	localparam int unsigned LUT_SIZE       = 1 << LUT_BITS;
	localparam logic [63:0] Z_LIMIT        = 64'hFF_FFFF;
	localparam logic [63:0] NEG1_Q32       = 64'd1580030169;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES   = 24;
	localparam int unsigned CYCLE_LIMIT    = 200000;

	typedef struct {
		logic [31:0] sample;
		logic [31:0] density;
		logic        in_tail;
	} density_word_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;   // [31:0] density
	logic        m_tuser;   // [0] in_tail
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_addr  = '0;
	logic [31:0] cfg_wdata = '0;

	// shadow copy of the configuration registers
	logic [31:0] center_q    = 32'd0;
	logic [31:0] inv_scale_q = 32'd65536;
	logic [23:0] thresh_q    = 24'd98304;
	logic [31:0] norm_q      = 32'd26145;

	// exp(-i) and exp(-k/2^LUT_BITS) in Q0.30
	logic [63:0] exp_int_rom  [LUT_SIZE];
	logic [63:0] exp_frac_rom [LUT_SIZE];

	density_word_t pending_densities [$];
	density_word_t want;
	int unsigned   error_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   tx_idle_pct = 26;
	int unsigned   rx_idle_pct = 26;
	int unsigned   hold_left   = 0;
	logic          rx_hold_req = 1'b0;

	huber_density_evaluator_top #(
		.EXP_LUT_BITS(LUT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// fill both exp tables
	task automatic build_exp_roms();
		logic [63:0] p;
		logic [63:0] t;
		logic [63:0] term;
		longint      sum;
		int          i;
		int          n;
		p = 64'd1 << 32;
		for (i = 0; i < LUT_SIZE; i++) begin
			exp_int_rom[i] = (p + 64'd2) >> 2;
			p = (p * NEG1_Q32 + (64'd1 << 31)) >> 32;
		end
		for (i = 0; i < LUT_SIZE; i++) begin
			t    = 64'(i) << (32 - LUT_BITS);
			term = 64'd1 << 32;
			sum  = longint'(64'd1 << 32);
			for (n = 1; n <= 16; n++) begin
				term = ((term * t) >> 32) / 64'(n);
				if (n % 2) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			exp_frac_rom[i] = (64'(sum) + 64'd2) >> 2;
		end
	endtask

	// density and tail flag for one sample under the current settings
	function automatic density_word_t huber_density_predict(input logic [31:0] x);
		density_word_t r;
		longint        diff;
		logic [63:0]   mag;
		logic [63:0]   prod;
		logic [64:0]   zw;
		logic [63:0]   z;
		logic [63:0]   v;
		logic [63:0]   twice_m;
		logic [63:0]   mq;
		logic [63:0]   g;
		logic [63:0]   dens;
		int unsigned   ipart;
		int unsigned   fidx;
		r.sample  = x;
		r.density = '0;
		r.in_tail = 1'b1;
		diff = longint'($signed(x)) - longint'($signed(center_q));
		mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
		prod = mag * 64'(inv_scale_q);
		zw   = ({1'b0, prod} + 65'h8000) >> 16;
		v    = 64'(thresh_q);
		// distance overflow: zero density, flagged as tail
		if (zw > 65'(Z_LIMIT))
			return r;
		z = zw[63:0];
		if (z <= v) begin
			r.in_tail = 1'b0;
			twice_m   = z * z;
		end else begin
			twice_m = 64'd2 * v * z - v * v;
		end
		mq = (twice_m + (64'd1 << 16)) >> 17;
		if (mq > Z_LIMIT)
			mq = Z_LIMIT;
		ipart = int'(mq >> 16);
		// integer part past the table gives zero density
		if (ipart < LUT_SIZE) begin
			fidx = int'((mq & 64'hFFFF) >> (16 - LUT_BITS));
			g    = (exp_int_rom[ipart] * exp_frac_rom[fidx] + (64'd1 << 29)) >> 30;
			dens = (g * 64'(norm_q) + (64'd1 << 29)) >> 30;
			if (dens > 64'hFFFF_FFFF)
				dens = 64'hFFFF_FFFF;
			r.density = dens[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] sample,
			input logic [31:0] got, input logic [31:0] exp_val);
		$display("[%0t] mismatch %s: sample %h got %h expected %h",
			$realtime, what, sample, got, exp_val);
		error_count++;
	endtask

	// offer one sample word, record its expected density on acceptance
	task automatic send_sample(input logic [31:0] x);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_densities.insert(pending_densities.size(), huber_density_predict(x));
	endtask

	// stop offering and wait for every outstanding density word
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_densities.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input hde_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			hde_pkg::REG_CENTER:         center_q    = val;
			hde_pkg::REG_INV_SCALE:      inv_scale_q = val;
			hde_pkg::REG_TAIL_THRESHOLD: thresh_q    = val[23:0];
			hde_pkg::REG_NORM_COEFF:     norm_q      = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] c, input logic [31:0] inv,
			input logic [31:0] v, input logic [31:0] norm);
		wait_results_done();
		write_reg(hde_pkg::REG_CENTER, c);
		write_reg(hde_pkg::REG_INV_SCALE, inv);
		write_reg(hde_pkg::REG_TAIL_THRESHOLD, v);
		write_reg(hde_pkg::REG_NORM_COEFF, norm);
	endtask

	// random sample, or one aimed at core, breakpoint or overflow under current settings
	function automatic logic [31:0] gen_sample();
		logic [63:0] zt;
		logic [63:0] d;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 20 || inv_scale_q == 0)
			return $urandom;
		if (pick < 32)
			zt = 64'(thresh_q) + 64'($urandom_range(1));
		else if (pick < 40)
			zt = Z_LIMIT - 64'd2 + 64'($urandom_range(4));
		else
			zt = 64'($urandom_range(0, 4 * thresh_q));
		d = (zt << 16) / 64'(inv_scale_q);
		if (d > 64'h7FFF_FFFF)
			d = 64'h7FFF_FFFF;
		if ($urandom_range(1))
			return center_q + d[31:0];
		return center_q - d[31:0];
	endfunction

	task automatic randomize_settings();
		logic [31:0] c;
		logic [31:0] inv;
		logic [31:0] v;
		logic [31:0] norm;
		if ($urandom_range(1))
			c = $urandom;
		else
			c = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
		inv = $urandom >> $urandom_range(0, 31);
		if (inv == 0)
			inv = 32'd1;
		v = $urandom >> $urandom_range(8, 31);
		// junk above bit 23 must be dropped
		if ($urandom_range(3) == 0)
			v = v | ($urandom << 24);
		if (v[23:0] == 0)
			v[0] = 1'b1;
		norm = $urandom >> $urandom_range(0, 16);
		set_config(c, inv, v, norm);
	endtask

	// directed points at the reset settings: center 0, scale 1.0, v 1.5
	task automatic test_reset_defaults();
		logic [31:0] pts [12] = '{
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0001_8000, 32'h0001_8001, 32'hFFFE_7FFF,
			32'h00FF_0000, 32'h00FF_FFFF, 32'h0100_0000, 32'hFFFF_8000
		};
		foreach (pts[i])
			send_sample(pts[i]);
	endtask

	// register extremes and the degenerate settings
	task automatic test_register_extremes();
		// zero reciprocal scale
		set_config(32'd0, 32'd0, 32'd98304, 32'd26145);
		send_sample(32'h1234_5678);
		send_sample(32'h8000_0000);
		// zero breakpoint
		set_config(32'd0, 32'd65536, 32'd0, 32'd26145);
		send_sample(32'h0001_0000);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_0000);
		// high threshold bits are masked off
		set_config(32'd0, 32'd65536, 32'hFF00_0001, 32'hFFFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0002);
		send_sample(32'h0001_0000);
		set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'd0);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFE);
		set_config(32'h8000_0000, 32'd1, 32'h00FF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h8000_8000);
	endtask

	// back-to-back traffic, no idling on either side
	task automatic test_no_idle_stream();
		set_config(32'h0001_0000, 32'h0002_0000, 32'h0000_C000, 32'h0001_0000);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (100)
			send_sample(gen_sample());
		tx_idle_pct = 26;
		rx_idle_pct = 26;
	endtask

	// receiver stalls for a long stretch while samples keep coming
	task automatic test_backpressure();
		randomize_settings();
		tx_idle_pct = 0;
		rx_hold_req = 1'b1;
		repeat (60)
			send_sample(gen_sample());
		tx_idle_pct = 26;
	endtask

	// random settings, random samples, full drain between phases
	task automatic test_random_settings();
		repeat (8) begin
			randomize_settings();
			repeat (55)
				send_sample(gen_sample());
		end
	endtask

	// receiver ready, with a counted hold-off on request
	always @(posedge clk) begin
		if (rx_hold_req) begin
			hold_left   = RX_HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// compare each density word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_densities.size() == 0) begin
				report_mismatch("unexpected word", 32'd0, m_tdata, 32'd0);
			end else begin
				want = pending_densities.pop_front();
				if (m_tdata !== want.density)
					report_mismatch("density", want.sample, m_tdata, want.density);
				if (m_tuser !== want.in_tail)
					report_mismatch("in_tail", want.sample, 32'(m_tuser), 32'(want.in_tail));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		build_exp_roms();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_register_extremes();
		test_no_idle_stream();
		test_backpressure();
		test_random_settings();
		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
src/hde_pkg.sv
src/hde_dist.sv
src/hde_expo.sv
src/hde_scale.sv
src/huber_density_evaluator_top.sv
test/huber_density_evaluator_top_tb.sv
